>>> rtl/core/css_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package css_pkg;

    // Number of rotation steps and the length of the arctangent table
    localparam int ITERATIONS = 16;
    localparam int TABLE_LEN  = 30;
    localparam int STEPS      = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
    localparam int SHIFT_W    = $clog2(TABLE_LEN);

    // Angle scaling to a binary angle, 2^31 stands for pi
    localparam logic [31:0] ANGLE_SCALE = 32'h0000_28be;
    localparam logic [31:0] HALF_TURN   = 32'h8000_0000;
    localparam logic [31:0] INV_GAIN    = 32'h18bd_e0bb;

    // Output rescale factor, positive, carried as a signed 20-bit value
    localparam logic signed [19:0] OUT_SCALE = 20'sh6488d;

    localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
        32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2E,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9,
        32'h0000_517C, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
        32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051, 32'h0000_0028,
        32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0002, 32'h0000_0001
    };

    // Rotation state handed from cell to cell
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        fold;
    } rot_t;

endpackage

`default_nettype wire

>>> rtl/core/css_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface css_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

`default_nettype wire

>>> rtl/core/css_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface css_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] sine;
    logic signed [17:0] cosine;

    modport source (output valid, output sine, output cosine, input ready);
    modport sink   (input valid, input sine, input cosine, output ready);
endinterface

`default_nettype wire

>>> rtl/core/css_pre.sv
`timescale 1ns / 1ps
`default_nettype none

module css_pre (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               valid,
    input  wire logic signed [31:0] angle,
    output logic                    rot_valid,
    output css_pkg::rot_t           rot
);

    logic          scl_valid_reg;
    logic [31:0]   scl_z_reg;
    logic [31:0]   scl_z_next;
    logic          fold_next;
    css_pkg::rot_t rot_reg;
    css_pkg::rot_t rot_next;
    logic          rot_valid_reg;

    // Scale radians to a binary angle, wrapping at 32 bits
    assign scl_z_next = 32'(angle * css_pkg::ANGLE_SCALE);

    // Fold second and third quadrants into the right half plane
    always_comb
    begin
        fold_next     = scl_z_reg[31] ^ scl_z_reg[30];
        rot_next.x    = css_pkg::INV_GAIN;
        rot_next.y    = '0;
        rot_next.fold = fold_next;
        rot_next.z    = fold_next ? (css_pkg::HALF_TURN - scl_z_reg) : scl_z_reg;
    end

    // Advance valid bits with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_valid_reg <= 1'b0;
            rot_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            scl_valid_reg <= valid;
            rot_valid_reg <= scl_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            scl_z_reg <= scl_z_next;
            rot_reg   <= rot_next;
        end
    end

    assign rot_valid = rot_valid_reg;
    assign rot       = rot_reg;

endmodule

`default_nettype wire

>>> rtl/core/css_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module css_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           adv,
    input  wire logic [css_pkg::SHIFT_W-1:0]    shift,
    input  wire logic [31:0]                    atan,
    input  wire logic                           valid_in,
    input  wire css_pkg::rot_t                  rot_in,
    output logic                                valid_out,
    output css_pkg::rot_t                       rot_out
);

    logic          valid_reg;
    css_pkg::rot_t rot_reg;
    css_pkg::rot_t rot_next;
    logic [31:0]   dx;
    logic [31:0]   dy;

    // One rotation step: direction from the sign of the residual angle
    always_comb
    begin
        dx = 32'($signed(rot_in.y) >>> shift);
        dy = 32'($signed(rot_in.x) >>> shift);
        rot_next.fold = rot_in.fold;
        if (!rot_in.z[31])
        begin
            rot_next.x = rot_in.x - dx;
            rot_next.y = rot_in.y + dy;
            rot_next.z = rot_in.z - atan;
        end
        else
        begin
            rot_next.x = rot_in.x + dx;
            rot_next.y = rot_in.y - dy;
            rot_next.z = rot_in.z + atan;
        end
    end

    // Hold valid across stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rot_reg <= rot_next;
    end

    assign valid_out = valid_reg;
    assign rot_out   = rot_reg;

endmodule

`default_nettype wire

>>> rtl/core/css_post.sv
`timescale 1ns / 1ps
`default_nettype none

module css_post (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               valid_in,
    input  wire css_pkg::rot_t      rot_in,
    output logic                    valid,
    output logic signed [17:0]      sine,
    output logic signed [17:0]      cosine
);

    logic signed [51:0] sin_prod;
    logic signed [51:0] cos_prod;
    logic               mul_valid_reg;
    logic [17:0]        mul_sin_reg;
    logic [17:0]        mul_cos_reg;
    logic               mul_fold_reg;
    logic               out_valid_reg;
    logic [17:0]        sine_reg;
    logic [17:0]        cosine_reg;
    logic [17:0]        cosine_next;

    // Rescale: keep the low 18 bits of the high word of each product
    assign sin_prod = $signed(rot_in.y) * css_pkg::OUT_SCALE;
    assign cos_prod = $signed(rot_in.x) * css_pkg::OUT_SCALE;

    // Negate the cosine of a folded angle
    assign cosine_next = mul_fold_reg ? (18'd0 - mul_cos_reg) : mul_cos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mul_valid_reg <= valid_in;
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_sin_reg  <= sin_prod[49:32];
            mul_cos_reg  <= cos_prod[49:32];
            mul_fold_reg <= rot_in.fold;
            sine_reg     <= mul_sin_reg;
            cosine_reg   <= cosine_next;
        end
    end

    assign valid  = out_valid_reg;
    assign sine   = sine_reg;
    assign cosine = cosine_reg;

endmodule

`default_nettype wire

>>> rtl/core/cordic_sin_cos_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// CORDIC sine and cosine unit.
// req carries one word per angle: signed 16.16 radians, any value, taken
// modulo two pi. rsp returns one word per angle with sine and cosine, each
// signed 2.16 in 18 bits, in the order the angles came in.
// The pipeline is 20 registers deep: an angle scaling register, a quadrant
// folding register, a register in each of the 16 rotation cells, a rescale
// multiply register and one output register. Throughput is one word per cycle
// while rsp is not stalled; the row of rotation cells sets the depth.
// All stages move together: when rsp.valid is high and rsp.ready low, the
// whole pipeline holds and req.ready drops in the same cycle, so nothing is
// lost. req.ready is high whenever the output register is empty or being
// taken, so a new word enters while earlier ones are still in the cells.
// Reset clears every valid bit; no word is in flight afterward and req.ready
// is high from the first cycle after reset.
module cordic_sin_cos_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    css_in_if.sink     req,
    css_out_if.source  rsp
);

    localparam int STEPS = css_pkg::STEPS;

    logic          adv;
    logic          out_valid;
    logic          cell_valid [STEPS+1];
    css_pkg::rot_t cell_rot   [STEPS+1];

    // Move the pipeline whenever the output register is free or drained
    assign adv       = !out_valid || rsp.ready;
    assign req.ready = adv;
    assign rsp.valid = out_valid;

    css_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid     (req.valid),
        .angle     (req.angle),
        .rot_valid (cell_valid[0]),
        .rot       (cell_rot[0])
    );

    // Row of rotation cells, one shift and one arctangent entry each
    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        css_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .shift     (css_pkg::SHIFT_W'(i)),
            .atan      (css_pkg::ATAN_TABLE[i]),
            .valid_in  (cell_valid[i]),
            .rot_in    (cell_rot[i]),
            .valid_out (cell_valid[i+1]),
            .rot_out   (cell_rot[i+1])
        );
    end

    css_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .valid_in (cell_valid[STEPS]),
        .rot_in   (cell_rot[STEPS]),
        .valid    (out_valid),
        .sine     (rsp.sine),
        .cosine   (rsp.cosine)
    );

endmodule

`default_nettype wire

>>> rtl/core/css_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module css_checker (
    input  wire logic  clk,
    input  wire logic  rst_n,
    css_in_if.sink     req,
    css_out_if.source  rsp
);

    // A stalled result word holds its valid and its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.sine) && $stable(rsp.cosine))
        else $error("result word changed while stalled");

    // Input side takes a word exactly when the output side can move
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready == (!rsp.valid || rsp.ready))
        else $error("req.ready does not follow output space");

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !rsp.valid)
        else $error("result word valid right after reset");

endmodule

bind cordic_sin_cos_unit css_checker u_css_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);

`default_nettype wire

>>> bench/sincos_checker.sv
`timescale 1ns / 1ps

// Watch both channels, predict sine and cosine for every angle taken in,
// and compare each returned word against the oldest prediction.
module sincos_checker (
    input  logic clk,
    input  logic rst_n,
    css_in_if    req,
    css_out_if   rsp,
    output int   fail_count,
    output int   pending,
    output int   words_in,
    output int   words_out,
    output int   input_stalls
);

    typedef struct packed {
        logic [17:0] sine;
        logic [17:0] cosine;
    } sincos_t;

    localparam int ROT_STEPS = (css_pkg::ITERATIONS > 30) ? 30 : css_pkg::ITERATIONS;

    localparam logic [31:0]        RAD_TO_BINANG = 32'h0000_28be;
    localparam logic [31:0]        PI_BINANG     = 32'h8000_0000;
    localparam logic [31:0]        X_START       = 32'h18bd_e0bb;
    localparam logic signed [63:0] GAIN_FIX      = 64'sh6488d;

    localparam logic [31:0] ARCTAN_STEP [30] = '{
        32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2E,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9,
        32'h0000_517C, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
        32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051, 32'h0000_0028,
        32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0002, 32'h0000_0001
    };

    sincos_t expected_sincos [$];
    int      errors = 0;

    // Rotate from the folded binary angle and rescale both coordinates
    function automatic sincos_t sincos_of_angle(input logic [31:0] angle);
        logic [31:0]        z;
        logic [31:0]        x;
        logic [31:0]        y;
        logic [31:0]        dx;
        logic [31:0]        dy;
        logic [31:0]        s32;
        logic [31:0]        c32;
        logic signed [63:0] ps;
        logic signed [63:0] pc;
        logic               fold;
        int                 t;
        sincos_t            r;
        z    = angle * RAD_TO_BINANG;
        fold = z[31] ^ z[30];
        if (fold)
            z = PI_BINANG - z;
        x = X_START;
        y = 32'd0;
        for (t = 0; t < ROT_STEPS; t++)
        begin
            dx = $signed(y) >>> t;
            dy = $signed(x) >>> t;
            if (!z[31])
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_STEP[t];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_STEP[t];
            end
        end
        ps  = $signed(y) * GAIN_FIX;
        pc  = $signed(x) * GAIN_FIX;
        s32 = ps[63:32];
        c32 = pc[63:32];
        if (fold)
            c32 = 32'd0 - c32;
        r.sine   = s32[17:0];
        r.cosine = c32[17:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    // Track both handshakes at each rising edge; clear the counts in reset
    always @(posedge clk)
    begin
        sincos_t want;
        if (rst_n)
        begin
            if (req.valid && !req.ready)
                input_stalls <= input_stalls + 1;
            if (req.valid && req.ready)
            begin
                expected_sincos.push_back(sincos_of_angle(req.angle));
                words_in <= words_in + 1;
            end
            if (rsp.valid && rsp.ready)
            begin
                words_out <= words_out + 1;
                if (expected_sincos.size() == 0)
                    flag_mismatch($sformatf("unexpected word sine=%h cosine=%h",
                                            rsp.sine, rsp.cosine));
                else
                begin
                    want = expected_sincos.pop_front();
                    if (rsp.sine !== want.sine)
                        flag_mismatch($sformatf("sine got %h want %h",
                                                rsp.sine, want.sine));
                    if (rsp.cosine !== want.cosine)
                        flag_mismatch($sformatf("cosine got %h want %h",
                                                rsp.cosine, want.cosine));
                end
            end
        end
        else
        begin
            input_stalls <= 0;
            words_in     <= 0;
            words_out    <= 0;
        end
        pending    <= expected_sincos.size();
        fail_count <= errors;
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_WORDS = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAD_HALF_PI  = 102944;
    localparam int RAD_TWO_PI   = 411775;

    // Extremes, bit patterns, axes and both sides of the quadrant folds
    localparam logic [31:0] CORNER_ANGLES [22] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h0000_FFFF, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_921F, 32'h0001_9220,
        32'hFFFE_6DE1, 32'h0003_243F, 32'hFFFC_DBC1, 32'h0004_B65F, 32'h0006_487F,
        32'h0002_5B2F, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_5A82, 32'h000C_90FE,
        32'h1234_5678, 32'h0004_B660
    };

    logic clk;
    logic rst_n;
    int   sent_words = 0;
    int   cycles     = 0;
    int   long_holds = 0;

    int fail_count;
    int pending;
    int words_in;
    int words_out;
    int input_stalls;

    css_in_if  req_ch ();
    css_out_if rsp_ch ();

    cordic_sin_cos_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sincos_checker check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .words_in     (words_in),
        .words_out    (words_out),
        .input_stalls (input_stalls)
    );

    initial
        clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // End the run if it hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d words still owed", cycles, pending);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Pick an angle: full range, a few turns around zero, or near a fold
    function automatic logic [31:0] pick_angle();
        int k;
        case ($urandom_range(0, 3))
            0, 1: return $urandom;
            2:    return int'($urandom_range(0, 8 * RAD_TWO_PI)) - 4 * RAD_TWO_PI;
            default:
            begin
                k = int'($urandom_range(0, 16)) - 8;
                return k * RAD_HALF_PI + int'($urandom_range(0, 40)) - 20;
            end
        endcase
    endfunction

    task automatic send_word(input logic [31:0] angle);
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.angle <= angle;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent_words++;
    endtask

    task automatic pause_sender(input int n);
        repeat (n)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
    endtask

    // Receiver: shifting stall patterns, plus two long hold-offs to fill the pipe
    initial
    begin
        int hold_left;
        int mode;
        int phase;
        hold_left = 0;
        mode      = 0;
        phase     = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ((long_holds == 0 && sent_words >= 150) ||
                (long_holds == 1 && sent_words >= 320))
            begin
                long_holds++;
                hold_left = 80;
            end
            phase++;
            if (phase % 50 == 0)
                mode = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= $urandom_range(0, 1);
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= (phase % 5) < 3;
                endcase
        end
    end

    // Sender: reset, corner angles, then random bursts
    initial
    begin
        int burst;
        int left;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.angle = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (CORNER_ANGLES[i])
            send_word(CORNER_ANGLES[i]);
        pause_sender(3);

        left = RANDOM_WORDS;
        while (left > 0)
        begin
            burst = $urandom_range(1, 16);
            if (burst > left)
                burst = left;
            repeat (burst)
                send_word(pick_angle());
            left -= burst;
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 6));
        end
        pause_sender(1);

        // Drain, then let any stray word show up
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d angles in, %0d sine/cosine words out", words_in, words_out);
        $display("input held off for %0d cycles, %0d long output hold-offs",
                 input_stalls, long_holds);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
